### src/mffra_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mffra_pkg
// Shared types and constants of the first-fit range allocator.
// ----------------------------------------------------------------------------
package mffra_pkg;

   localparam int NUM_CHANNELS = 8;
   localparam int MAX_RANGES   = 32;
   localparam int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int POS_W        = $clog2(MAX_RANGES);
   localparam int CNT_W        = $clog2(MAX_RANGES + 1);
   localparam int DEPTH        = NUM_CHANNELS * MAX_RANGES;
   localparam int ADDR_W       = $clog2(DEPTH);
   localparam int ENTRY_W      = 64;
   localparam logic [31:0] RESET_CHANNEL_SIZE = 32'd1073741824;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BAD_SIZE  = 3'd1;
   localparam logic [2:0] ST_START_OVL = 3'd2;
   localparam logic [2:0] ST_END_OVL   = 3'd3;
   localparam logic [2:0] ST_NO_SPACE  = 3'd4;
   localparam logic [2:0] ST_FULL      = 3'd5;

   typedef enum logic [2:0] {
      S_IDLE, S_CHECK, S_READ, S_SCAN, S_SHIFT_RD, S_SHIFT_WR, S_PLACE, S_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;     // capture request
      logic check;    // evaluate size check
      logic eval;     // evaluate entry just read
      logic rd_shift; // issue read of entry k-1
      logic wr_shift; // write entry k from read data, k--
      logic place;    // write new entry, bump count
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic decided;   // result status known
      logic fail;      // decided, no placement
      logic scan_end;  // scan index reached count
      logic shift_end; // shift index reached insert position
   } sts_type;

endpackage

### src/mffra_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mffra_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mffra_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

### src/mffra_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mffra_ctrl
// Sequencer: scan the list, shift entries up, place, deliver the beat.
// ----------------------------------------------------------------------------
module mffra_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  mffra_pkg::sts_type   sts,
   output mffra_pkg::cmd_type   cmd
);
   mffra_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mffra_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // READ issues the read of the scan entry and acts on the last outcome
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mffra_pkg::S_IDLE:     if (req_valid) state_in = mffra_pkg::S_CHECK;
         mffra_pkg::S_CHECK:    state_in = mffra_pkg::S_READ;
         mffra_pkg::S_READ: begin
            if (sts.decided)       state_in = sts.fail ? mffra_pkg::S_DONE
                                                       : mffra_pkg::S_SHIFT_RD;
            else if (sts.scan_end) state_in = mffra_pkg::S_PLACE;
            else                   state_in = mffra_pkg::S_SCAN;
         end
         mffra_pkg::S_SCAN:     state_in = mffra_pkg::S_READ;
         mffra_pkg::S_SHIFT_RD: state_in = sts.shift_end ? mffra_pkg::S_PLACE
                                                         : mffra_pkg::S_SHIFT_WR;
         mffra_pkg::S_SHIFT_WR: state_in = mffra_pkg::S_SHIFT_RD;
         mffra_pkg::S_PLACE:    state_in = mffra_pkg::S_DONE;
         mffra_pkg::S_DONE:     if (!rsp_stall) state_in = mffra_pkg::S_IDLE;
         default:               state_in = mffra_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         mffra_pkg::S_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         mffra_pkg::S_CHECK:    cmd.check    = 1'b1;
         mffra_pkg::S_SCAN:     cmd.eval     = 1'b1;
         mffra_pkg::S_SHIFT_RD: cmd.rd_shift = 1'b1;
         mffra_pkg::S_SHIFT_WR: cmd.wr_shift = 1'b1;
         mffra_pkg::S_PLACE:    cmd.place    = 1'b1;
         mffra_pkg::S_DONE:     rsp_valid    = 1'b1;
         default: ;
      endcase
   end

   a_one_busy: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && !req_stall)) else $error("accept while result pending");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid) else $error("result dropped");
   a_place_done: assert property (@(posedge clock) disable iff (reset)
      cmd.place |=> rsp_valid) else $error("place not followed by result");
endmodule

### src/mffra_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mffra_dp
// Request registers, range memory, per-channel counts and the compare logic.
// ----------------------------------------------------------------------------
module mffra_dp (
   input  logic                clock,
   input  logic                reset,
   input  mffra_pkg::cmd_type  cmd,
   output mffra_pkg::sts_type  sts,
   input  logic                csr_write,
   input  logic [31:0]         csr_wdata,
   input  logic                req_op,
   input  logic [2:0]          req_channel,
   input  logic [31:0]         req_start_addr,
   input  logic [31:0]         req_length,
   output logic [2:0]          rsp_status,
   output logic [31:0]         rsp_granted_addr
);
   localparam int CW = mffra_pkg::CNT_W;

   logic [31:0] size_ff;
   logic [mffra_pkg::CNT_W-1:0] count_ff [mffra_pkg::NUM_CHANNELS];
   logic        op_ff, bad_ch_ff;
   logic [mffra_pkg::CH_W-1:0] ch_ff;
   logic [31:0] start_ff, len_ff;
   logic [CW-1:0] idx_ff;    // scan index, later shift index k
   logic [CW-1:0] pos_ff;    // insert position
   logic [32:0]  prev_end_ff;
   logic        decided_ff, fail_ff;
   logic [2:0]  status_ff;
   logic [31:0] addr_ff;
   logic [CW-1:0] n;

   logic        wr_en;
   logic [mffra_pkg::ADDR_W-1:0] wr_addr, rd_addr;
   logic [63:0] wr_data, rd_data;
   logic        tail_fits;
   logic        place_ok;
   logic [31:0] new_start;

   assign n = count_ff[ch_ff];

   function automatic logic [mffra_pkg::ADDR_W-1:0] ent(
         input logic [mffra_pkg::CH_W-1:0] c, input logic [CW-1:0] p);
      logic [mffra_pkg::ADDR_W:0] a;
      a = (mffra_pkg::ADDR_W+1)'(c) * (mffra_pkg::ADDR_W+1)'(mffra_pkg::MAX_RANGES)
        + (mffra_pkg::ADDR_W+1)'(p);
      return a[mffra_pkg::ADDR_W-1:0];
   endfunction

   mffra_ram #(.WIDTH(mffra_pkg::ENTRY_W), .DEPTH(mffra_pkg::DEPTH)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data));

   // Entry just read
   logic [32:0] s, e;
   assign s = {1'b0, rd_data[63:32]};
   assign e = s + {1'b0, rd_data[31:0]};

   logic full;
   assign full = (n >= CW'(mffra_pkg::MAX_RANGES));

   // tail free space after the last entry, ends kept in 33 bits
   assign tail_fits = (prev_end_ff < {1'b0, size_ff}) &&
                      (prev_end_ff + {1'b0, len_ff} <= {1'b0, size_ff});
   // a scan hit always places; a tail needs room (allocate) and a free slot
   assign place_ok  = cmd.place && (decided_ff || (!full && (!op_ff || tail_fits)));
   assign new_start = (op_ff && !decided_ff) ? prev_end_ff[31:0] : addr_ff;

   always_comb begin
      rd_addr = ent(ch_ff, idx_ff);
      if (cmd.rd_shift) rd_addr = ent(ch_ff, idx_ff - CW'(1));
      wr_en   = cmd.wr_shift || place_ok;
      wr_addr = cmd.wr_shift ? ent(ch_ff, idx_ff) : ent(ch_ff, decided_ff ? pos_ff : n);
      wr_data = cmd.wr_shift ? rd_data : {new_start, len_ff};
   end

   assign sts.decided   = decided_ff;
   assign sts.fail      = fail_ff;
   assign sts.scan_end  = (idx_ff >= n);
   assign sts.shift_end = (idx_ff == pos_ff);
   assign rsp_status       = status_ff;
   assign rsp_granted_addr = (status_ff == mffra_pkg::ST_OK) ? addr_ff : 32'd0;

   logic [32:0] gap;
   assign gap = s - prev_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= mffra_pkg::RESET_CHANNEL_SIZE;
         for (int c = 0; c < mffra_pkg::NUM_CHANNELS; c++) count_ff[c] <= '0;
      end else begin
         if (csr_write) size_ff <= csr_wdata;
         if (place_ok) count_ff[ch_ff] <= n + CW'(1);
      end

      if (cmd.load) begin
         op_ff       <= req_op;
         ch_ff       <= mffra_pkg::CH_W'(req_channel);
         bad_ch_ff   <= ({29'd0, req_channel} >= 32'(mffra_pkg::NUM_CHANNELS));
         start_ff    <= req_start_addr;
         len_ff      <= req_length;
         idx_ff      <= '0;
         prev_end_ff <= '0;
         decided_ff  <= 1'b0;
         fail_ff     <= 1'b0;
      end
      if (cmd.check) begin
         addr_ff <= op_ff ? 32'd0 : start_ff;
         if (bad_ch_ff || len_ff == 32'd0 || len_ff > size_ff ||
             (!op_ff && ({1'b0, start_ff} + {1'b0, len_ff} > {1'b0, size_ff}))) begin
            decided_ff <= 1'b1;
            fail_ff    <= 1'b1;
            status_ff  <= mffra_pkg::ST_BAD_SIZE;
         end
      end
      if (cmd.eval) begin
         if (!op_ff) begin
            if (s <= {1'b0, start_ff}) begin
               if (e > {1'b0, start_ff}) begin
                  decided_ff <= 1'b1; fail_ff <= 1'b1;
                  status_ff  <= mffra_pkg::ST_START_OVL;
               end
            end else if (s - {1'b0, start_ff} < {1'b0, len_ff}) begin
               decided_ff <= 1'b1; fail_ff <= 1'b1;
               status_ff  <= mffra_pkg::ST_END_OVL;
            end else begin
               decided_ff <= 1'b1; fail_ff <= full;
               status_ff  <= full ? mffra_pkg::ST_FULL : mffra_pkg::ST_OK;
               pos_ff     <= idx_ff;
               idx_ff     <= full ? idx_ff : n;
            end
         end else begin
            if (s >= prev_end_ff && gap >= {1'b0, len_ff}) begin
               decided_ff <= 1'b1; fail_ff <= full;
               status_ff  <= full ? mffra_pkg::ST_FULL : mffra_pkg::ST_OK;
               addr_ff    <= prev_end_ff[31:0];
               pos_ff     <= idx_ff;
               idx_ff     <= full ? idx_ff : n;
            end
            prev_end_ff <= e;
         end
         if (!decided_ff && !(
             (!op_ff && s > {1'b0, start_ff} && !(s - {1'b0, start_ff} < {1'b0, len_ff})) ||
             (op_ff && s >= prev_end_ff && gap >= {1'b0, len_ff}) ||
             (!op_ff && s <= {1'b0, start_ff} && e > {1'b0, start_ff}) ||
             (!op_ff && s > {1'b0, start_ff})))
            idx_ff <= idx_ff + CW'(1);
      end
      if (cmd.wr_shift) idx_ff <= idx_ff - CW'(1);
      // Scan ran out: tail placement decided here
      if (cmd.place) begin
         if (!decided_ff) begin
            if (op_ff) begin
               if (tail_fits) begin
                  status_ff <= full ? mffra_pkg::ST_FULL : mffra_pkg::ST_OK;
                  addr_ff   <= prev_end_ff[31:0];
               end else begin
                  status_ff <= mffra_pkg::ST_NO_SPACE;
               end
            end else begin
               status_ff <= full ? mffra_pkg::ST_FULL : mffra_pkg::ST_OK;
            end
         end
      end
   end
endmodule

### src/multichannel_first_fit_range_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_first_fit_range_allocator
// Per-channel sorted range lists with reserve and first-fit allocate.
// ----------------------------------------------------------------------------
// One request is handled at a time. A request walks its channel's sorted list
// entry by entry through the single read port of the range memory, then moves
// later entries up one place, each with a read and a write, before inserting.
// A beat rejected on its size skips the scan. A result beat waits in the
// output register until taken; the next request is accepted once it has gone.
// ----------------------------------------------------------------------------
module multichannel_first_fit_range_allocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [31:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [2:0]  req_channel,
   input  logic [31:0] req_start_addr,
   input  logic [31:0] req_length,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_granted_addr
);
   mffra_pkg::cmd_type cmd;
   mffra_pkg::sts_type sts;

   mffra_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .sts(sts), .cmd(cmd));

   mffra_dp u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .csr_write(csr_write), .csr_wdata(csr_wdata),
      .req_op(req_op), .req_channel(req_channel),
      .req_start_addr(req_start_addr), .req_length(req_length),
      .rsp_status(rsp_status), .rsp_granted_addr(rsp_granted_addr));
endmodule

### dv/range_alloc_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_alloc_tb_pkg
// Request codes shared by the allocator stimulus and its checker.
// ----------------------------------------------------------------------------
package range_alloc_tb_pkg;

   localparam logic OP_RESERVE  = 1'b0;
   localparam logic OP_ALLOCATE = 1'b1;

endpackage

### dv/range_alloc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_alloc_checker
// Tracks every channel's range table, predicts each grant and checks the
// result beats in order.
// ----------------------------------------------------------------------------
module range_alloc_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [31:0] csr_wdata,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_op,
   input  logic [2:0]  req_channel,
   input  logic [31:0] req_start_addr,
   input  logic [31:0] req_length,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [2:0]  rsp_status,
   input  logic [31:0] rsp_granted_addr,
   output int          fail_count,
   output int          pending
);

   localparam int NUM_CH   = mffra_pkg::NUM_CHANNELS;
   localparam int MAX_RNG  = mffra_pkg::MAX_RANGES;
   localparam int FIFO_LEN = 64;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] addr;
   } grant_type;

   logic [31:0] chan_size;
   logic [31:0] starts  [NUM_CH][MAX_RNG];
   logic [31:0] lengths [NUM_CH][MAX_RNG];
   int          used    [NUM_CH];
   grant_type   grant_fifo [FIFO_LEN];
   int          wr_ptr;
   int          rd_ptr;

   assign pending = wr_ptr - rd_ptr;

   // insert at pos, moving later entries up; 0 when the table is full
   function automatic logic insert_range(int ch, int pos, logic [31:0] s, logic [31:0] l);
      int n;
      n = used[ch];
      if (n >= MAX_RNG) return 1'b0;
      for (int k = n; k > pos; k--) begin
         starts[ch][k]  = starts[ch][k-1];
         lengths[ch][k] = lengths[ch][k-1];
      end
      starts[ch][pos]  = s;
      lengths[ch][pos] = l;
      used[ch] = n + 1;
      return 1'b1;
   endfunction

   function automatic grant_type predict_grant(logic op, logic [2:0] ch,
                                               logic [31:0] s, logic [31:0] l);
      grant_type g;
      int        n;
      int        pos;
      logic      found;
      logic [32:0] prev_end;
      logic [32:0] st;
      g = '{status: mffra_pkg::ST_OK, addr: '0};
      n = used[ch];
      pos = n;
      found = 1'b0;
      if (op == range_alloc_tb_pkg::OP_RESERVE) begin
         if (l == 0 || l > chan_size || s > chan_size || s > chan_size - l) begin
            g.status = mffra_pkg::ST_BAD_SIZE;
         end else begin
            for (int i = 0; i < n; i++) begin
               st = {1'b0, starts[ch][i]};
               if (st <= {1'b0, s}) begin
                  if (st + lengths[ch][i] > {1'b0, s}) begin
                     g.status = mffra_pkg::ST_START_OVL;
                     break;
                  end
               end else begin
                  if (st - s < {1'b0, l}) g.status = mffra_pkg::ST_END_OVL;
                  pos = i;
                  break;
               end
            end
            if (g.status == mffra_pkg::ST_OK) begin
               if (insert_range(ch, pos, s, l)) g.addr = s;
               else g.status = mffra_pkg::ST_FULL;
            end
         end
      end else begin
         if (l == 0 || l > chan_size) begin
            g.status = mffra_pkg::ST_BAD_SIZE;
         end else begin
            prev_end = '0;
            for (int i = 0; i < n; i++) begin
               st = {1'b0, starts[ch][i]};
               if (st >= prev_end && st - prev_end >= {1'b0, l}) begin
                  pos = i;
                  found = 1'b1;
                  break;
               end
               prev_end = st + lengths[ch][i];
            end
            if (!found && prev_end < {1'b0, chan_size} &&
                prev_end <= {1'b0, chan_size} - l) begin
               pos = n;
               found = 1'b1;
            end
            if (!found) g.status = mffra_pkg::ST_NO_SPACE;
            else if (insert_range(ch, pos, prev_end[31:0], l)) g.addr = prev_end[31:0];
            else g.status = mffra_pkg::ST_FULL;
         end
      end
      return g;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t: MISMATCH %s: got 0x%08h, want 0x%08h", $realtime, what, got, want);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      wr_ptr     = 0;
      rd_ptr     = 0;
   end

   always @(posedge clock) begin
      grant_type want;
      if (reset) begin
         chan_size = mffra_pkg::RESET_CHANNEL_SIZE;
         foreach (used[c]) used[c] = 0;
         wr_ptr = 0;
         rd_ptr = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (wr_ptr == rd_ptr) begin
               report_mismatch("unexpected result beat", rsp_granted_addr, '0);
            end else begin
               want = grant_fifo[rd_ptr % FIFO_LEN];
               rd_ptr++;
               if (rsp_status !== want.status)
                  report_mismatch("status", rsp_status, want.status);
               if (rsp_granted_addr !== want.addr)
                  report_mismatch("granted_addr", rsp_granted_addr, want.addr);
            end
         end
         if (req_valid && !req_stall) begin
            grant_fifo[wr_ptr % FIFO_LEN] =
               predict_grant(req_op, req_channel, req_start_addr, req_length);
            wr_ptr++;
         end
         if (csr_write) chan_size = csr_wdata;
      end
   end

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Directed and random reserve/allocate traffic for the range allocator.
// ----------------------------------------------------------------------------
// Stimulus runs in phases, one channel size each (reset size, full 32-bit
// space, tiny spaces and a shrunk size over existing tables). Each phase mixes
// first-fit allocates, reserves inside the space and raw noise beats, with
// random gaps on the request side and random stalls on the result side. The
// checker beside the DUT predicts and compares; this module drives the DUT.
// ----------------------------------------------------------------------------
module tb_top;

   localparam logic OP_RESERVE  = range_alloc_tb_pkg::OP_RESERVE;
   localparam logic OP_ALLOCATE = range_alloc_tb_pkg::OP_ALLOCATE;

   localparam int WATCHDOG_LIMIT = 4000;  // covers the longest beat plus the longest stall
   localparam int ITEMS_PER_PHASE = 300;

   logic        clock;
   logic        reset;
   logic        csr_write;
   logic [31:0] csr_wdata;
   logic        req_valid;
   logic        req_stall;
   logic        req_op;
   logic [2:0]  req_channel;
   logic [31:0] req_start_addr;
   logic [31:0] req_length;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_granted_addr;

   int          fail_count;
   int          pending;
   int          beats_sent;
   int          beats_back;
   int          quiet_cycles;
   int          phases_run;
   logic        no_idle;        // stretches with neither gaps nor stalls
   logic [31:0] size_now;

   multichannel_first_fit_range_allocator u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_write),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_channel      (req_channel),
      .req_start_addr   (req_start_addr),
      .req_length       (req_length),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_granted_addr (rsp_granted_addr)
   );

   range_alloc_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_write),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_channel      (req_channel),
      .req_start_addr   (req_start_addr),
      .req_length       (req_length),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_granted_addr (rsp_granted_addr),
      .fail_count       (fail_count),
      .pending          (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // beat counters and the watchdog on handshakes
   always @(posedge clock) begin
      if (reset) begin
         beats_sent   <= 0;
         beats_back   <= 0;
         quiet_cycles <= 0;
      end else begin
         if (req_valid && !req_stall) beats_sent <= beats_sent + 1;
         if (rsp_valid && !rsp_stall) beats_back <= beats_back + 1;
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles <= 0;
         end else if (req_valid || beats_sent != beats_back) begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
               $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
               $display("multichannel_first_fit_range_allocator test failed");
               $finish;
            end
         end
      end
   end

   // result-side stalls: mostly short runs, now and then a long one
   initial begin
      int hold;
      int r;
      hold = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (no_idle) begin
            rsp_stall <= 1'b0;
            hold = 0;
         end else if (hold > 0) begin
            hold--;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
               rsp_stall <= 1'b0;
               hold = $urandom_range(0, 8);
            end else if (r < 95) begin
               rsp_stall <= 1'b1;
               hold = $urandom_range(0, 3);
            end else begin
               rsp_stall <= 1'b1;
               hold = $urandom_range(10, 60);
            end
         end
      end
   end

   // drive one beat at the falling edge and hold it until taken
   task automatic send_beat(logic op, logic [2:0] ch, logic [31:0] s, logic [31:0] l);
      int gap;
      req_valid      <= 1'b1;
      req_op         <= op;
      req_channel    <= ch;
      req_start_addr <= s;
      req_length     <= l;
      do @(posedge clock); while (!(req_valid && !req_stall));
      @(negedge clock);
      gap = 0;
      if (!no_idle)
         gap = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(5, 40);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // register write only once every result is back
   task automatic set_channel_size(logic [31:0] value);
      @(negedge clock);
      req_valid <= 1'b0;
      while (beats_back != beats_sent) @(negedge clock);
      csr_write <= 1'b1;
      csr_wdata <= value;
      size_now  = value;
      @(negedge clock);
      csr_write <= 1'b0;
      phases_run++;
   endtask

   function automatic logic [31:0] pick_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80)
         return $urandom_range(1, (size_now >= 16) ? size_now / 16 : 1);
      else if (r < 88) return size_now;
      else if (r < 92) return size_now + 1;
      else if (r < 95) return '0;
      else return $urandom();
   endfunction

   task automatic random_phase(int count);
      int r;
      logic [31:0] s;
      for (int i = 0; i < count; i++) begin
         if (i % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
         r = $urandom_range(0, 99);
         s = (size_now > 0) ? $urandom_range(0, size_now - 1) : '0;
         if (r < 45)
            send_beat(OP_ALLOCATE, 3'($urandom_range(0, 7)), $urandom(), pick_length());
         else if (r < 85)
            send_beat(OP_RESERVE, 3'($urandom_range(0, 7)), s, pick_length());
         else
            send_beat(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                      $urandom(), $urandom());
      end
      no_idle = 1'b0;
   endtask

   initial begin
      reset          = 1'b1;
      csr_write      = 1'b0;
      csr_wdata      = '0;
      req_valid      = 1'b0;
      req_op         = OP_RESERVE;
      req_channel    = '0;
      req_start_addr = '0;
      req_length     = '0;
      no_idle        = 1'b0;
      phases_run     = 1;
      size_now       = mffra_pkg::RESET_CHANNEL_SIZE;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: fits, both overlaps, bad sizes, exact gaps and tails
      send_beat(OP_RESERVE,  3'd0, 32'h0000_1000, 32'h0000_1000);
      send_beat(OP_RESERVE,  3'd0, 32'h0000_1800, 32'h0000_0010);  // starts inside
      send_beat(OP_RESERVE,  3'd0, 32'h0000_0800, 32'h0000_1000);  // runs into next
      send_beat(OP_RESERVE,  3'd0, 32'h0000_2000, 32'h0000_0000);  // zero length
      send_beat(OP_RESERVE,  3'd0, 32'h3FFF_FFFF, 32'h0000_0002);  // past the end
      send_beat(OP_RESERVE,  3'd0, 32'h0000_0000, 32'hFFFF_FFFF);
      send_beat(OP_RESERVE,  3'd0, 32'hFFFF_FFFF, 32'h0000_0001);
      send_beat(OP_ALLOCATE, 3'd0, 32'hFFFF_FFFF, 32'h0000_1000);  // gap exactly fits
      send_beat(OP_ALLOCATE, 3'd0, 32'h0000_0000, 32'h4000_0000);  // no space
      send_beat(OP_ALLOCATE, 3'd1, 32'h0000_0000, 32'h4000_0000);  // whole space
      send_beat(OP_ALLOCATE, 3'd1, 32'h0000_0000, 32'h0000_0001);
      send_beat(OP_ALLOCATE, 3'd0, 32'h0000_0000, 32'h0000_0000);
      send_beat(OP_RESERVE,  3'd7, 32'h3FFF_F000, 32'h0000_1000);  // ends at the top
      send_beat(OP_RESERVE,  3'd7, 32'h3FFF_EFFF, 32'h0000_1000);  // runs into it from below
      send_beat(OP_ALLOCATE, 3'd7, 32'h0000_0000, 32'h4000_0001);
      for (int i = 0; i < 6; i++)
         send_beat(OP_ALLOCATE, 3'd2, 32'h0, 32'h10);
      random_phase(ITEMS_PER_PHASE);

      set_channel_size(32'hFFFF_FFFF);
      send_beat(OP_RESERVE,  3'd4, 32'h0000_0000, 32'hFFFF_FFFF);
      send_beat(OP_ALLOCATE, 3'd5, 32'h0000_0000, 32'hFFFF_FFFF);
      random_phase(ITEMS_PER_PHASE);
      set_channel_size(32'd4096);
      random_phase(ITEMS_PER_PHASE);
      set_channel_size(32'd1);
      random_phase(ITEMS_PER_PHASE / 2);
      set_channel_size(32'd64);
      random_phase(ITEMS_PER_PHASE);
      set_channel_size(32'h1000_0000);  // shrunk below older entries
      random_phase(ITEMS_PER_PHASE);

      @(negedge clock);
      req_valid <= 1'b0;
      while (beats_back != beats_sent) @(negedge clock);
      repeat (200) @(posedge clock);

      $display("Sent %0d request beats, %0d results returned.", beats_sent, beats_back);
      $display("Covered %0d channel-size settings, from 1 byte to the full 4 GiB.",
               phases_run);
      if (fail_count == 0 && pending == 0) begin
         $display("multichannel_first_fit_range_allocator test passed");
      end else begin
         $display("%0d mismatches, %0d results outstanding", fail_count, pending);
         $display("multichannel_first_fit_range_allocator test failed");
      end
      $finish;
   end

endmodule

### sim.f
src/mffra_pkg.sv
src/mffra_ram.sv
src/mffra_ctrl.sv
src/mffra_dp.sv
src/multichannel_first_fit_range_allocator.sv
dv/range_alloc_tb_pkg.sv
dv/range_alloc_checker.sv
dv/tb_top.sv
